// ===== hw/rtl/acc_cpu_pkg.sv =====
// Package for the accumulator CPU core: payload structs, opcodes, constants.
// No dependencies.
package acc_cpu_pkg;

  typedef struct packed {
    logic        action;
    logic [16:0] load_address;
    logic [7:0]  load_data;
    logic [15:0] port_read_data;
  } acc_in_t;

  typedef struct packed {
    logic [31:0] accumulator;
    logic [1:0]  flags;
    logic [31:0] next_pc;
    logic        halted;
    logic [2:0]  port_request;
    logic [15:0] port_address;
    logic [15:0] port_write_data;
  } acc_out_t;

  localparam logic [4:0] OP_BRK  = 5'd0;
  localparam logic [4:0] OP_LD   = 5'd1;
  localparam logic [4:0] OP_ST   = 5'd2;
  localparam logic [4:0] OP_INB  = 5'd3;
  localparam logic [4:0] OP_OUTB = 5'd4;
  localparam logic [4:0] OP_INW  = 5'd5;
  localparam logic [4:0] OP_OUTW = 5'd6;
  localparam logic [4:0] OP_JMP  = 5'd7;
  localparam logic [4:0] OP_CALL = 5'd8;
  localparam logic [4:0] OP_RET  = 5'd9;
  localparam logic [4:0] OP_ADD  = 5'd10;
  localparam logic [4:0] OP_ADC  = 5'd11;
  localparam logic [4:0] OP_SUB  = 5'd12;
  localparam logic [4:0] OP_SBC  = 5'd13;
  localparam logic [4:0] OP_NOT  = 5'd14;
  localparam logic [4:0] OP_OR   = 5'd15;
  localparam logic [4:0] OP_AND  = 5'd16;
  localparam logic [4:0] OP_XOR  = 5'd17;
  localparam logic [4:0] OP_JF   = 5'd18;
  localparam logic [4:0] OP_POP  = 5'd19;
  localparam logic [4:0] OP_PUSH = 5'd20;

  localparam logic [2:0] PREQ_NONE = 3'd0;
  localparam logic [2:0] PREQ_RDB  = 3'd1;
  localparam logic [2:0] PREQ_RDW  = 3'd2;
  localparam logic [2:0] PREQ_WRB  = 3'd3;
  localparam logic [2:0] PREQ_WRW  = 3'd4;

  localparam logic [16:0] START_RESET = 17'h10000;

  // stack depth in bytes; indices wrap at this power of two
  localparam int STACK_BYTES = 256;
  localparam int SB          = $clog2(STACK_BYTES);

endpackage

// ===== hw/rtl/acc_cpu_alu.sv =====
// Shared ALU of the accumulator CPU: add/subtract with carry rules and logic ops.
// Depends on acc_cpu_pkg.
module acc_cpu_alu import acc_cpu_pkg::*; (
  input  logic [4:0]  opc_i,
  input  logic        word_i,
  input  logic [31:0] acc_i,
  input  logic [31:0] op_i,
  input  logic [1:0]  flags_i,
  output logic [31:0] acc_o,
  output logic [1:0]  flags_o
);
  logic [31:0] a, r, total;
  logic        cin, sub, carry;

  always_comb begin
    a     = word_i ? acc_i : {24'd0, acc_i[7:0]};
    cin   = (opc_i == OP_ADC || opc_i == OP_SBC) ? flags_i[1] : 1'b0;
    sub   = (opc_i == OP_SUB || opc_i == OP_SBC);
    total = op_i + {31'd0, cin};
    r     = sub ? (a - total) : (a + total);
    if (sub) carry = (a <= r) && (total != 32'd0);
    else if (word_i) carry = (a >= r) && (total != 32'd0);
    else carry = (r > 32'hFF);
    acc_o   = acc_i;
    flags_o = flags_i;
    case (opc_i)
      OP_ADD, OP_ADC, OP_SUB, OP_SBC: begin
        acc_o   = (carry && !word_i) ? {24'd0, r[7:0]} : r;
        flags_o = carry ? 2'b11 : 2'b00;
      end
      OP_NOT, OP_OR, OP_AND, OP_XOR: begin
        case (opc_i)
          OP_NOT:  r = ~acc_i;
          OP_OR:   r = acc_i | op_i;
          OP_AND:  r = acc_i & op_i;
          default: r = acc_i ^ op_i;
        endcase
        if (!word_i) r = {24'd0, r[7:0]};
        acc_o      = r;
        flags_o[0] = (r != 32'd0);
      end
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/accumulator_stack_cpu_core.sv =====
// Top level of the accumulator CPU core: sequencer, byte memory, stacks.
// Depends on acc_cpu_pkg and acc_cpu_alu.
//
// Usage: an item is a transaction on start/in_i while busy is low. A memory
// write item stores one byte in S_WRITE, then S_DONE registers done_o.
// An execute item fetches five instruction bytes through the single byte
// memory port (S_FETCH), then passes S_IND once per indirection level (0 to
// 3), then S_EXEC, then the memory or stack phase, then the S_DONE report.
// Memory/stack phase: S_STORE for a store, S_STK for a push or call, and
// S_STKRD for a pop or return; all other opcodes skip it.
// An execute while halted goes straight to S_DONE.
// A new transaction can be taken at the edge that ends the done_o cycle;
// busy is high from acceptance until done_o, so items do not overlap.
// The result appears for one cycle with done_o; the receiver cannot stall.
// The configuration channel (cfg_valid_i/cfg_ready_o) is always ready; the
// written start_address is held, but reset returns it to START_RESET.
// Reset: registers clear, pc loads START_RESET, then a pass over every stack
// entry clears both stacks with busy high. Memory is not cleared.
module accumulator_stack_cpu_core import acc_cpu_pkg::*; #(
  parameter int MEM_ADDR_BITS = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  acc_in_t     in_i,
  output logic        done_o,
  output acc_out_t    out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_FETCH, S_IND, S_EXEC, S_STORE, S_STK, S_STKRD, S_DONE
  } state_e;

  state_e state_q;
  logic [7:0]  mem [2**MEM_ADDR_BITS];
  logic [7:0]  rdata_q;
  logic [7:0]  dstk [STACK_BYTES];
  logic [7:0]  cstk [STACK_BYTES];
  logic [7:0]  drd_q, crd_q;
  logic        dwe, cwe;
  logic [7:0]  dwd, cwd;
  logic [1:0]  bsel;
  logic [16:0] start_q;
  logic [31:0] acc_q, pc_q, op_q, tmp_q;
  logic [1:0]  flag_q;
  logic        halt_q;
  logic [SB-1:0] dsi_q, csi_q, sp_q;
  logic [7:0]  head_q;
  logic [2:0]  cnt_q;
  logic [1:0]  lvl_q;
  logic [31:0] maddr_q;
  logic        we;
  logic [7:0]  wdata;
  acc_in_t     in_q;
  acc_out_t    res_q;
  logic [31:0] alu_acc;
  logic [1:0]  alu_flags;
  logic [4:0]  opc;

  assign opc = head_q[4:0];
  assign cfg_ready_o = 1'b1;
  assign busy = (state_q != S_IDLE);
  // byte lane for stack reads, one behind the issue count
  assign bsel = cnt_q[1:0] - 2'd1;

  acc_cpu_alu u_alu (
    .opc_i(opc), .word_i(head_q[5]), .acc_i(acc_q), .op_i(op_q),
    .flags_i(flag_q), .acc_o(alu_acc), .flags_o(alu_flags)
  );

  // byte memory, one port, registered read
  always_ff @(posedge clk_i) begin
    if (we) mem[maddr_q[MEM_ADDR_BITS-1:0]] <= wdata;
    rdata_q <= mem[maddr_q[MEM_ADDR_BITS-1:0]];
  end

  always_comb begin
    we    = 1'b0;
    wdata = in_q.load_data;
    if (state_q == S_WRITE) we = 1'b1;
    if (state_q == S_STORE) begin
      we    = 1'b1;
      wdata = acc_q[8*cnt_q[1:0] +: 8];
    end
  end

  // stacks, one port each at sp_q, registered read; cleared after reset
  always_comb begin
    dwe = 1'b0;
    cwe = 1'b0;
    dwd = acc_q[8*cnt_q[1:0] +: 8];
    cwd = pc_q[8*cnt_q[1:0] +: 8];
    if (state_q == S_CLEAR) begin
      dwe = 1'b1; cwe = 1'b1; dwd = '0; cwd = '0;
    end
    if (state_q == S_STK && opc == OP_PUSH) dwe = 1'b1;
    if (state_q == S_STK && opc == OP_CALL) cwe = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (dwe) dstk[sp_q] <= dwd;
    if (cwe) cstk[sp_q] <= cwd;
    drd_q <= dstk[sp_q];
    crd_q <= cstk[sp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; start_q <= START_RESET; acc_q <= '0; flag_q <= '0;
      pc_q <= {15'd0, START_RESET}; halt_q <= 1'b0; dsi_q <= '0; csi_q <= '0;
      done_o <= 1'b0; head_q <= '0; op_q <= '0; tmp_q <= '0;
      cnt_q <= '0; lvl_q <= '0; maddr_q <= '0; sp_q <= '0;
      in_q <= '0; res_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (cfg_valid_i) start_q <= cfg_data_i;
      unique case (state_q)
        S_CLEAR: begin
          sp_q <= sp_q + SB'(1);
          if (&sp_q) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            in_q <= in_i;
            if (!in_i.action) begin
              maddr_q <= {15'd0, in_i.load_address}; state_q <= S_WRITE;
            end else if (halt_q) begin
              state_q <= S_DONE;
            end else begin
              maddr_q <= pc_q; cnt_q <= '0; state_q <= S_FETCH;
            end
            res_q.port_request <= PREQ_NONE;
            res_q.port_address <= '0; res_q.port_write_data <= '0;
          end
        end
        S_WRITE: state_q <= S_DONE;
        S_FETCH, S_IND: begin
          // address issued last cycle, data in rdata_q now when cnt>0
          maddr_q <= maddr_q + 32'd1;
          cnt_q <= cnt_q + 3'd1;
          if (state_q == S_FETCH) begin
            if (cnt_q == 3'd1) head_q <= rdata_q;
            if (cnt_q >= 3'd2) op_q <= {rdata_q, op_q[31:8]};
            if (cnt_q == 3'd5) begin
              lvl_q <= head_q[7:6]; cnt_q <= '0;
              maddr_q <= {rdata_q, op_q[31:8]};
              state_q <= (head_q[7:6] != 2'd0) ? S_IND : S_EXEC;
            end
          end else begin
            if (cnt_q >= 3'd1) tmp_q <= {rdata_q, tmp_q[31:8]};
            if (cnt_q == 3'd4) begin
              op_q <= {rdata_q, tmp_q[31:8]}; maddr_q <= {rdata_q, tmp_q[31:8]};
              cnt_q <= '0; lvl_q <= lvl_q - 2'd1;
              if (lvl_q == 2'd1) state_q <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          pc_q <= pc_q + 32'd5; cnt_q <= '0;
          state_q <= S_DONE;
          case (opc)
            OP_BRK: halt_q <= 1'b1;
            OP_LD: acc_q <= head_q[5] ? op_q : {24'd0, op_q[7:0]};
            OP_ST: begin
              maddr_q <= op_q; state_q <= S_STORE;
            end
            OP_INB: begin
              res_q.port_request <= PREQ_RDB; res_q.port_address <= op_q[15:0];
              acc_q <= {24'd0, in_q.port_read_data[7:0]};
            end
            OP_OUTB: begin
              res_q.port_request <= PREQ_WRB; res_q.port_address <= op_q[15:0];
              res_q.port_write_data <= {8'd0, acc_q[7:0]};
            end
            OP_INW: begin
              res_q.port_request <= PREQ_RDW; res_q.port_address <= op_q[15:0];
              acc_q <= {16'd0, in_q.port_read_data};
            end
            OP_OUTW: begin
              res_q.port_request <= PREQ_WRW; res_q.port_address <= op_q[15:0];
              res_q.port_write_data <= acc_q[15:0];
            end
            OP_JMP: pc_q <= op_q;
            OP_CALL: begin
              pc_q <= pc_q + 32'd5; sp_q <= csi_q; tmp_q <= op_q; state_q <= S_STK;
            end
            OP_RET: begin
              sp_q <= csi_q - SB'(4); csi_q <= csi_q - SB'(4); state_q <= S_STKRD;
            end
            OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_NOT, OP_OR, OP_AND, OP_XOR: begin
              acc_q <= alu_acc; flag_q <= alu_flags;
            end
            OP_JF: if (flag_q[0]) pc_q <= op_q;
            OP_POP: begin
              sp_q  <= dsi_q - (head_q[5] ? SB'(4) : SB'(1));
              dsi_q <= dsi_q - (head_q[5] ? SB'(4) : SB'(1));
              state_q <= S_STKRD;
            end
            OP_PUSH: begin sp_q <= dsi_q; state_q <= S_STK; end
            default: ;
          endcase
        end
        S_STORE: begin
          maddr_q <= maddr_q + 32'd1; cnt_q <= cnt_q + 3'd1;
          if (!head_q[5] || cnt_q == 3'd3) state_q <= S_DONE;
        end
        S_STK: begin
          // push or call: one byte written per cycle
          sp_q <= sp_q + SB'(1); cnt_q <= cnt_q + 3'd1;
          case (opc)
            OP_PUSH: dsi_q <= dsi_q + SB'(1);
            OP_CALL: csi_q <= csi_q + SB'(1);
            default: ;
          endcase
          if (!head_q[5] && opc == OP_PUSH) state_q <= S_DONE;
          else if (cnt_q == 3'd3) begin
            state_q <= S_DONE;
            if (opc == OP_CALL) pc_q <= tmp_q;
          end
        end
        S_STKRD: begin
          // pop or return: read data is registered, so it lags the issued position
          sp_q <= sp_q + SB'(1); cnt_q <= cnt_q + 3'd1;
          if (cnt_q != 3'd0) begin
            if (opc == OP_RET) pc_q[8*bsel +: 8] <= crd_q;
            else if (head_q[5]) acc_q[8*bsel +: 8] <= drd_q;
            else acc_q <= {24'd0, drd_q};
          end
          if ((cnt_q == 3'd1 && opc == OP_POP && !head_q[5]) || cnt_q == 3'd4)
            state_q <= S_DONE;
        end
        S_DONE: begin
          done_o <= 1'b1;
          res_q.accumulator <= acc_q; res_q.flags <= flag_q;
          res_q.next_pc <= pc_q; res_q.halted <= halt_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o = res_q;
endmodule

// ===== hw/rtl/acc_cpu_checker.sv =====
// Port-level checker for the accumulator CPU core, bound to the top level.
// Depends on acc_cpu_pkg.
module acc_cpu_checker import acc_cpu_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     done_o,
  input acc_out_t out_o
);
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("not busy after start");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("busy while reporting");
  a_preq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> out_o.port_request <= PREQ_WRW) else $error("bad port request");
endmodule

bind accumulator_stack_cpu_core acc_cpu_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .out_o(out_o)
);

// ===== dv/accumulator_stack_cpu_core_tb.sv =====
// Testbench for accumulator_stack_cpu_core: random and directed programs, scoreboard check.
// Depends on acc_cpu_pkg and the core RTL; self-contained otherwise.
module accumulator_stack_cpu_core_tb;
  import acc_cpu_pkg::*;

  localparam int unsigned MEM_BYTES   = 1 << 17;
  localparam logic [16:0] MEM_MASK    = 17'h1FFFF;
  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned PHASE_ITEMS = 300;
  localparam int unsigned DRAIN_WAIT  = 40;   // beyond worst-case core latency

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  acc_in_t     in_i;
  logic        done_o;
  acc_out_t    out_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [16:0] cfg_data_i;

  accumulator_stack_cpu_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .done_o      (done_o),
    .out_o       (out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the core's architectural state. It is advanced when an item
  // is generated; items are accepted in the same order, so expected results
  // line up with what the core reports.
  // ---------------------------------------------------------------------------
  logic [7:0]  mem_img   [MEM_BYTES];
  bit          mem_known [MEM_BYTES];   // never let the core read an unknown byte
  logic [16:0] start_reg;
  logic [31:0] acc_q, pc_q;
  logic [1:0]  flag_q;
  logic        halt_q;
  logic [7:0]  dstk [256];
  logic [7:0]  cstk [256];
  logic [7:0]  dsp, csp;

  acc_in_t  pending_q [$];   // items waiting for the driver
  acc_out_t result_q  [$];   // results the core still owes

  int unsigned n_exec, n_load, n_checked, n_mismatch, cycles;
  int unsigned sender_idle_pct;

  function automatic logic [31:0] mem_word(logic [31:0] a);
    logic [31:0] v;
    v = '0;
    for (int k = 0; k < 4; k++) v[8*k +: 8] = mem_img[(a + k) & MEM_MASK];
    return v;
  endfunction

  function automatic void mem_put(logic [31:0] a, logic [7:0] d);
    mem_img[a & MEM_MASK]   = d;
    mem_known[a & MEM_MASK] = 1'b1;
  endfunction

  // add/sub family; carry/borrow sets both flags
  function automatic void alu_arith(logic [31:0] opnd, bit word, bit sub, logic [31:0] cin);
    logic [31:0] a, old, total;
    bit          cy;
    a     = word ? acc_q : {24'h0, acc_q[7:0]};
    old   = a;
    total = opnd + cin;
    if (sub) begin
      a  = a - opnd - cin;
      cy = (old <= a) && (total != 0);
    end else begin
      a  = a + opnd + cin;
      cy = word ? ((old >= a) && (total != 0)) : (a > 32'hFF);
    end
    if (cy) begin
      if (!word) a = a & 32'hFF;
      flag_q = 2'b11;
    end else begin
      flag_q = 2'b00;
    end
    acc_q = a;
  endfunction

  function automatic void alu_logic(logic [31:0] v, bit word);
    if (!word) v = v & 32'hFF;
    acc_q = v;
    if (v != 0) flag_q[0] = 1'b1;
    else        flag_q[0] = 1'b0;
  endfunction

  // Advance the shadow state by one item and return the result it produces.
  function automatic acc_out_t cpu_next(acc_in_t it);
    acc_out_t    r;
    logic [7:0]  head;
    logic [31:0] opnd, cin;
    logic [4:0]  opc;
    bit          word;
    r = '0;
    if (!it.action) begin
      mem_put({15'h0, it.load_address}, it.load_data);
    end else if (!halt_q) begin
      head = mem_img[pc_q & MEM_MASK];
      word = head[5];
      opc  = head[4:0];
      opnd = mem_word(pc_q + 1);
      cin  = {31'h0, flag_q[1]};
      for (int k = 0; k < head[7:6]; k++) opnd = mem_word(opnd);
      pc_q = pc_q + 5;
      case (opc)
        OP_BRK:  halt_q = 1'b1;
        OP_LD:   acc_q = word ? opnd : (opnd & 32'hFF);
        OP_ST: begin
          if (word) for (int k = 0; k < 4; k++) mem_put(opnd + k, acc_q[8*k +: 8]);
          else      mem_put(opnd, acc_q[7:0]);
        end
        OP_INB: begin
          r.port_request = PREQ_RDB; r.port_address = opnd[15:0];
          acc_q = {24'h0, it.port_read_data[7:0]};
        end
        OP_OUTB: begin
          r.port_request = PREQ_WRB; r.port_address = opnd[15:0];
          r.port_write_data = {8'h0, acc_q[7:0]};
        end
        OP_INW: begin
          r.port_request = PREQ_RDW; r.port_address = opnd[15:0];
          acc_q = {16'h0, it.port_read_data};
        end
        OP_OUTW: begin
          r.port_request = PREQ_WRW; r.port_address = opnd[15:0];
          r.port_write_data = acc_q[15:0];
        end
        OP_JMP:  pc_q = opnd;
        OP_CALL: begin
          for (int k = 0; k < 4; k++) cstk[8'(csp + k)] = pc_q[8*k +: 8];
          pc_q = opnd;
          csp  = csp + 8'd4;
        end
        OP_RET: begin
          csp = csp - 8'd4;
          for (int k = 0; k < 4; k++) pc_q[8*k +: 8] = cstk[8'(csp + k)];
        end
        OP_ADD:  alu_arith(opnd, word, 1'b0, 32'h0);
        OP_ADC:  alu_arith(opnd, word, 1'b0, cin);
        OP_SUB:  alu_arith(opnd, word, 1'b1, 32'h0);
        OP_SBC:  alu_arith(opnd, word, 1'b1, cin);
        OP_NOT:  alu_logic(~acc_q, word);
        OP_OR:   alu_logic(acc_q | opnd, word);
        OP_AND:  alu_logic(acc_q & opnd, word);
        OP_XOR:  alu_logic(acc_q ^ opnd, word);
        OP_JF:   if (flag_q[0]) pc_q = opnd;
        OP_POP: begin
          if (word) begin
            dsp = dsp - 8'd4;
            for (int k = 0; k < 4; k++) acc_q[8*k +: 8] = dstk[8'(dsp + k)];
          end else begin
            dsp   = dsp - 8'd1;
            acc_q = {24'h0, dstk[dsp]};
          end
        end
        OP_PUSH: begin
          if (word) begin
            for (int k = 0; k < 4; k++) dstk[8'(dsp + k)] = acc_q[8*k +: 8];
            dsp = dsp + 8'd4;
          end else begin
            dstk[dsp] = acc_q[7:0];
            dsp       = dsp + 8'd1;
          end
        end
        default: ;  // unused opcodes only move the pc
      endcase
    end
    r.accumulator = acc_q;
    r.flags       = flag_q;
    r.next_pc     = pc_q;
    r.halted      = halt_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers: every item goes through the shadow model on the way in.
  // ---------------------------------------------------------------------------
  task automatic queue_item(acc_in_t it);
    result_q.push_back(cpu_next(it));
    pending_q.push_back(it);
    if (it.action) n_exec++;
    else           n_load++;
  endtask

  task automatic poke_byte(logic [31:0] a, logic [7:0] d);
    acc_in_t it;
    it.action         = 1'b0;
    it.load_address   = a[16:0];
    it.load_data      = d;
    it.port_read_data = 16'($urandom);
    queue_item(it);
  endtask

  task automatic poke_word(logic [31:0] a, logic [31:0] v);
    for (int k = 0; k < 4; k++) poke_byte(a + k, v[8*k +: 8]);
  endtask

  task automatic fill_if_unknown(logic [31:0] a);
    if (!mem_known[a & MEM_MASK]) poke_byte(a, 8'($urandom));
  endtask

  // Make sure every byte the next execute will read is known; optionally
  // replace a break opcode so the core keeps running.
  task automatic prepare_fetch(bit no_break);
    logic [7:0]  head;
    logic [31:0] opnd;
    for (int k = 0; k < 5; k++) fill_if_unknown(pc_q + k);
    head = mem_img[pc_q & MEM_MASK];
    if (no_break && head[4:0] == OP_BRK)
      poke_byte(pc_q, {head[7:5], 5'($urandom_range(1, 31))});
    head = mem_img[pc_q & MEM_MASK];
    opnd = mem_word(pc_q + 1);
    for (int l = 0; l < head[7:6]; l++) begin
      for (int k = 0; k < 4; k++) fill_if_unknown(opnd + k);
      opnd = mem_word(opnd);
    end
  endtask

  task automatic run_exec(logic [15:0] prd);
    acc_in_t it;
    it.action         = 1'b1;
    it.load_address   = 17'($urandom);
    it.load_data      = 8'($urandom);
    it.port_read_data = prd;
    queue_item(it);
  endtask

  // Write one instruction at the pc with an indirection chain that ends in
  // value, then execute it.
  task automatic run_instr(logic [4:0] opc, bit word, logic [1:0] lv,
                           logic [31:0] value, logic [15:0] prd);
    logic [31:0] ptr [3];
    logic [31:0] field;
    for (int l = 0; l < lv; l++)
      ptr[l] = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 32'h1FFFF));
    for (int l = 0; l < lv; l++)
      poke_word(ptr[l], (l == lv - 1) ? value : ptr[l + 1]);
    field = (lv == 0) ? value : ptr[0];
    poke_byte(pc_q, {lv, word, opc});
    poke_word(pc_q + 1, field);
    prepare_fetch(opc != OP_BRK);
    run_exec(prd);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0;
      2:       return 32'($urandom_range(0, 255));
      3:       return 32'($urandom_range(0, 32'h1FFFF));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      run_instr(5'($urandom_range(1, 31)), 1'($urandom), 2'($urandom), rand_value(),
                16'($urandom));
    end else if (pick < 90) begin
      prepare_fetch(1'b1);   // whatever is already sitting at the pc
      run_exec(16'($urandom));
    end else begin
      poke_byte($urandom, 8'($urandom));
    end
  endtask

  task automatic directed_items();
    run_instr(OP_JMP,  1'b1, 2'd0, 32'h0001_FFFD, 16'h0);   // fetch/operand wrap at the top
    run_instr(OP_LD,   1'b1, 2'd3, 32'hFFFF_FFFF, 16'h0);
    run_instr(OP_ADD,  1'b1, 2'd0, 32'h1,         16'h0);   // word carry
    run_instr(OP_ADC,  1'b1, 2'd1, 32'h0,         16'h0);   // carry in only
    run_instr(OP_SUB,  1'b0, 2'd0, 32'h1,         16'h0);   // byte subtract without borrow
    run_instr(OP_SBC,  1'b1, 2'd2, 32'h7FFF_FFFF, 16'h0);
    run_instr(OP_JF,   1'b0, 2'd0, 32'h0000_0100, 16'h0);
    run_instr(OP_NOT,  1'b0, 2'd0, 32'h0,         16'h0);
    run_instr(OP_OR,   1'b1, 2'd0, 32'h8000_0001, 16'h0);
    run_instr(OP_AND,  1'b1, 2'd0, 32'h0,         16'h0);   // zero clears bit0
    run_instr(OP_JF,   1'b1, 2'd0, 32'h0000_0200, 16'h0);   // not taken
    run_instr(OP_XOR,  1'b0, 2'd0, 32'hFF,        16'h0);
    run_instr(OP_INW,  1'b1, 2'd0, 32'hFFFF_FFFF, 16'hFFFF);
    run_instr(OP_OUTW, 1'b1, 2'd0, 32'h0,         16'h0);
    run_instr(OP_INB,  1'b0, 2'd1, 32'h0000_1234, 16'h00FF);
    run_instr(OP_OUTB, 1'b0, 2'd0, 32'hFFFF,      16'h0);
    run_instr(OP_ST,   1'b1, 2'd0, 32'h0001_FFFE, 16'h0);   // store wraps to address 0
    run_instr(OP_ST,   1'b0, 2'd0, 32'h0000_0040, 16'h0);
    run_instr(OP_PUSH, 1'b1, 2'd0, 32'h0,         16'h0);
    run_instr(OP_PUSH, 1'b0, 2'd0, 32'h0,         16'h0);
    run_instr(OP_POP,  1'b0, 2'd0, 32'h0,         16'h0);
    run_instr(OP_POP,  1'b1, 2'd0, 32'h0,         16'h0);
    run_instr(OP_POP,  1'b1, 2'd0, 32'h0,         16'h0);   // data stack wraps below zero
    run_instr(OP_CALL, 1'b1, 2'd0, 32'h0000_3000, 16'h0);
    run_instr(OP_RET,  1'b0, 2'd0, 32'h0,         16'h0);
    run_instr(OP_RET,  1'b0, 2'd0, 32'h0,         16'h0);   // call stack wraps
    run_instr(5'd31,   1'b1, 2'd0, 32'h0,         16'h0);   // unused opcode
    poke_byte(32'h0, 8'h00);
    poke_byte(32'h1FFFF, 8'hFF);
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // the core never loads the written start_address, so writes change no result
  task automatic write_start(logic [16:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    start_reg    = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: holds an item on in_i until the core takes it.
  // ---------------------------------------------------------------------------
  logic took;

  always @(posedge clk_i) took <= start && !busy;

  always @(negedge clk_i) begin
    if (!start || took) begin
      if (took) void'(pending_q.pop_front());
      if (rst_ni && pending_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_i  <= pending_q[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done_o pulse is one result transaction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    acc_out_t want;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected result transaction: %p", out_o);
      end else begin
        want = result_q.pop_front();
        n_checked++;
        if (out_o.accumulator !== want.accumulator || out_o.flags !== want.flags ||
            out_o.next_pc !== want.next_pc || out_o.halted !== want.halted ||
            out_o.port_request !== want.port_request ||
            out_o.port_address !== want.port_address ||
            out_o.port_write_data !== want.port_write_data) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch on result %0d", n_checked);
            $display("  expected acc=%h flg=%b pc=%h halt=%b preq=%0d padr=%h pwd=%h",
                     want.accumulator, want.flags, want.next_pc, want.halted,
                     want.port_request, want.port_address, want.port_write_data);
            $display("  actual   acc=%h flg=%b pc=%h halt=%b preq=%0d padr=%h pwd=%h",
                     out_o.accumulator, out_o.flags, out_o.next_pc, out_o.halted,
                     out_o.port_request, out_o.port_address, out_o.port_write_data);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, then three phases with different sender pacing.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mark;
    rst_ni          = 1'b0;
    start           = 1'b0;
    in_i            = '0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    sender_idle_pct = 6;
    cycles          = 0;
    n_exec = 0; n_load = 0; n_checked = 0; n_mismatch = 0;
    start_reg = START_RESET;
    acc_q = '0; flag_q = '0; halt_q = 1'b0; dsp = '0; csp = '0;
    pc_q  = {15'h0, START_RESET};
    for (int i = 0; i < 256; i++) begin
      dstk[i] = '0;
      cstk[i] = '0;
    end
    for (int i = 0; i < MEM_BYTES; i++) begin
      mem_img[i]   = '0;
      mem_known[i] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_start(17'h0);
    directed_items();
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 86 : 0;
      mark = n_exec + n_load;
      while (n_exec + n_load - mark < PHASE_ITEMS) random_item();
      if (ph == 2) begin
        // break, then the halted core must ignore executes
        run_instr(OP_BRK, 1'($urandom), 2'd0, $urandom, 16'h0);
        run_exec(16'hFFFF);
        poke_byte($urandom, 8'($urandom));
        run_exec(16'h0);
      end
      drain();
      if (ph == 0)      write_start(17'h1FFFF);
      else if (ph == 1) write_start(17'($urandom));
    end

    $display("ran %0d execute and %0d memory-load transactions, %0d results checked",
             n_exec, n_load, n_checked);
    $display("three pacing phases, start_address written 3 times, %0d mismatches",
             n_mismatch);
    if (n_mismatch == 0 && result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
